FILE: rtl/ptkt_pkg.sv
// ----------------------------------------------------------------------------
// ptkt_pkg
// Types and constants shared by the pressure trend kill trigger modules.
// ----------------------------------------------------------------------------
package ptkt_pkg;

    localparam int ACC_W = 24;   // window sums, fit numerator and denominator
    localparam int DIV_W = 24;   // shared divider operand width
    localparam int PROD_W = 48;  // memory floor products

    localparam logic [2:0] REG_SWAP_RESERVE = 3'd0;
    localparam logic [2:0] REG_ANON_MIN     = 3'd1;
    localparam logic [2:0] REG_CLEAN_MIN    = 3'd2;
    localparam logic [2:0] REG_SLOPE_THR    = 3'd3;
    localparam logic [2:0] REG_HARD_LIMIT   = 3'd4;

    localparam logic [1:0] LEVEL_CRITICAL  = 2'd2;

    typedef struct packed {
        logic [6:0]  pressure;
        logic [1:0]  level;
        logic [15:0] reactivation_count;
        logic [15:0] alloc_failure_count;
        logic [15:0] swap_refault_count;
        logic [31:0] scanned_pages;
        logic [31:0] reclaimed_pages;
        logic [39:0] total_kb;
        logic [39:0] anon_kb;
        logic [39:0] file_kb;
        logic [39:0] dirty_file_kb;
        logic [39:0] swap_avail_kb;
    } in_t;

    typedef struct packed {
        logic               kill_request;
        logic               regression;
        logic signed [11:0] trend_slope;
        logic               anon_starved;
        logic               clean_starved;
        logic               swap_short;
    } out_t;

    typedef struct packed {
        logic [19:0] swap_reserve_kb;
        logic [6:0]  anon_min_pct;
        logic [6:0]  clean_min_pct;
        logic [9:0]  slope_threshold;
        logic [9:0]  hard_pressure_limit;
    } cfg_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;    // take the input transaction, push the sample
        logic acc_step;   // add one window entry to the sums
        logic div_start;  // start the shared divider
        logic div_sel;    // 0: mean of samples, 1: slope quotient
        logic calc_mx;    // latch mean of y, form n * mean of x
        logic calc_nd;    // form fit numerator and denominator
        logic finish;     // load the result register
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic acc_last;
        logic short_n;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

FILE: rtl/ptkt_div.sv
// ----------------------------------------------------------------------------
// ptkt_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptkt_div #(
    parameter int W = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     q_reg, q_next;
    logic [W-1:0]     r_reg, r_next;
    logic [W-1:0]     d_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [W:0]       r_sh;
    logic [W:0]       diff;

    always_comb begin
        r_sh      = {r_reg, q_reg[W-1]};
        diff      = r_sh - {1'b0, d_reg};
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            q_next   = dividend;
            r_next   = '0;
            cnt_next = CNT_W'(W);
        end else if (cnt_reg != '0) begin
            if (!diff[W]) begin
                r_next = diff[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = r_sh[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        if (start) begin
            d_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: rtl/ptkt_dp.sv
// ----------------------------------------------------------------------------
// ptkt_dp
// Datapath: sample window, fit sums, shared divider, floor flags, result.
// ----------------------------------------------------------------------------
module ptkt_dp #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  ptkt_pkg::cmd_t cmd,
    output ptkt_pkg::sts_t sts,
    input  ptkt_pkg::cfg_t cfg,
    input  ptkt_pkg::in_t  s_data,
    input  logic          m_ready,
    output logic          m_valid,
    output ptkt_pkg::out_t m_data
);
    import ptkt_pkg::*;

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    logic [6:0]        win_reg [WINDOW_DEPTH];
    logic [AW-1:0]     wptr_reg, wptr_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     idx_reg;
    logic [CW-1:0]     i_reg;
    logic [ACC_W-1:0]  sy_reg, sxy_reg, sxx_reg;
    logic [ACC_W-1:0]  my_reg, t1_reg;
    logic signed [ACC_W-1:0] num_reg;
    logic [ACC_W-1:0]  den_reg;
    in_t               in_reg;

    logic [PROD_W-1:0] anon_floor_reg, clean_floor_reg;
    logic [PROD_W-1:0] anon100_reg, clean100_reg;
    logic [35:0]       recl10_reg;

    logic              m_valid_reg;
    out_t              m_data_reg;

    logic [CW:0]       st_w;
    logic [CW-1:0]     mx_w;
    logic [6:0]        y_w;
    logic [39:0]       clean_w;
    logic [DIV_W-1:0]  div_a, div_b, quo;
    logic              div_done;
    logic [ACC_W-1:0]  num_mag;
    logic signed [11:0] slope_w;
    logic              anon_low, clean_low, swap_low, reg_w;

    always_comb begin
        wptr_next = (wptr_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        cnt_next  = (cnt_reg < CW'(WINDOW_DEPTH)) ? cnt_reg + 1'b1 : cnt_reg;
        if ((CW+1)'(wptr_next) >= (CW+1)'(cnt_next)) begin
            st_w = (CW+1)'(wptr_next) - (CW+1)'(cnt_next);
        end else begin
            st_w = (CW+1)'(wptr_next) + (CW+1)'(WINDOW_DEPTH) - (CW+1)'(cnt_next);
        end
        y_w  = win_reg[idx_reg];
        mx_w = (cnt_reg - 1'b1) >> 1;
    end

    // Window, pointers and fit sums.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            cnt_reg  <= '0;
        end else if (cmd.capture) begin
            wptr_reg <= wptr_next;
            cnt_reg  <= cnt_next;
        end
        if (cmd.capture) begin
            in_reg            <= s_data;
            win_reg[wptr_reg] <= s_data.pressure;
            idx_reg           <= st_w[AW-1:0];
            i_reg             <= '0;
            sy_reg            <= '0;
            sxy_reg           <= '0;
            sxx_reg           <= '0;
        end else if (cmd.acc_step) begin
            sy_reg  <= sy_reg + ACC_W'(y_w);
            sxy_reg <= sxy_reg + ACC_W'(i_reg) * ACC_W'(y_w);
            sxx_reg <= sxx_reg + ACC_W'(i_reg) * ACC_W'(i_reg);
            i_reg   <= i_reg + 1'b1;
            idx_reg <= (idx_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : idx_reg + 1'b1;
        end
        if (cmd.calc_mx) begin
            my_reg <= quo;
            t1_reg <= ACC_W'(cnt_reg) * ACC_W'(mx_w);
        end
        if (cmd.calc_nd) begin
            num_reg <= $signed(sxy_reg) - $signed(t1_reg * my_reg);
            den_reg <= sxx_reg - t1_reg * ACC_W'(mx_w);
        end
    end

    assign sts.acc_last = (i_reg == cnt_reg - 1'b1);
    assign sts.short_n  = (cnt_reg < CW'(2));
    assign sts.div_done = div_done;
    assign sts.out_free = !m_valid_reg || m_ready;

    // Shared divider: mean of samples, then the slope quotient on magnitudes.
    assign num_mag = num_reg[ACC_W-1] ? ACC_W'(-num_reg) : ACC_W'(num_reg);
    assign div_a   = cmd.div_sel ? DIV_W'(num_mag) : DIV_W'(sy_reg);
    assign div_b   = cmd.div_sel ? DIV_W'(den_reg) : DIV_W'(cnt_reg);

    ptkt_div #(.W(DIV_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (quo)
    );

    // Floor products; the held input settles them before the result is loaded.
    assign clean_w = (in_reg.file_kb > in_reg.dirty_file_kb) ?
                     in_reg.file_kb - in_reg.dirty_file_kb : '0;

    always_ff @(posedge aclk) begin
        anon_floor_reg  <= PROD_W'(in_reg.total_kb) * PROD_W'(cfg.anon_min_pct);
        clean_floor_reg <= PROD_W'(in_reg.total_kb) * PROD_W'(cfg.clean_min_pct);
        anon100_reg     <= PROD_W'((PROD_W'(in_reg.anon_kb) + 1'b1) * 7'd100);
        clean100_reg    <= PROD_W'((PROD_W'(clean_w) + 1'b1) * 7'd100);
        recl10_reg      <= 36'(in_reg.reclaimed_pages) * 36'(10);
    end

    // a < floor(p / 100) exactly when (a + 1) * 100 <= p.
    assign anon_low  = anon100_reg <= anon_floor_reg;
    assign clean_low = clean100_reg <= clean_floor_reg;
    assign swap_low  = in_reg.swap_avail_kb < 40'(cfg.swap_reserve_kb);

    always_comb begin
        if (sts.short_n) begin
            slope_w = '0;
        end else if (num_reg[ACC_W-1]) begin
            slope_w = (quo > DIV_W'(2048)) ? -12'sd2048 : -$signed(12'(quo));
        end else begin
            slope_w = (quo > DIV_W'(2047)) ? 12'sd2047 : $signed(12'(quo));
        end
        reg_w = (10'(in_reg.pressure) >= cfg.hard_pressure_limit) ||
                ($signed(slope_w) >= $signed({2'b00, cfg.slope_threshold})) ||
                (in_reg.alloc_failure_count != '0) ||
                (in_reg.level >= LEVEL_CRITICAL) ||
                (clean_low && in_reg.swap_refault_count != '0) ||
                ((in_reg.reactivation_count > 16'd4) && (in_reg.scanned_pages != '0) &&
                 (recl10_reg < 36'(in_reg.scanned_pages)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.finish) begin
            m_data_reg.kill_request  <= reg_w || swap_low;
            m_data_reg.regression    <= reg_w;
            m_data_reg.trend_slope   <= slope_w;
            m_data_reg.anon_starved  <= anon_low;
            m_data_reg.clean_starved <= clean_low;
            m_data_reg.swap_short    <= swap_low;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/ptkt_ctrl.sv
// ----------------------------------------------------------------------------
// ptkt_ctrl
// Sequencer for one pressure event: sum pass, then mean divide, fit and slope divide for two or more samples.
// ----------------------------------------------------------------------------
module ptkt_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ptkt_pkg::sts_t sts,
    output ptkt_pkg::cmd_t cmd
);
    import ptkt_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ACC    = 3'd1;
    localparam logic [2:0] ST_MEAN   = 3'd2;
    localparam logic [2:0] ST_MEANW  = 3'd3;
    localparam logic [2:0] ST_FIT    = 3'd4;
    localparam logic [2:0] ST_SLOPE  = 3'd5;
    localparam logic [2:0] ST_SLOPEW = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       nd_reg, nd_next;

    always_comb begin
        state_next = state_reg;
        nd_next    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.acc_step = 1'b1;
                if (sts.acc_last) begin
                    state_next = sts.short_n ? ST_DONE : ST_MEAN;
                end
            end
            ST_MEAN: begin
                cmd.div_start = 1'b1;
                state_next    = ST_MEANW;
            end
            ST_MEANW: begin
                if (sts.div_done) begin
                    state_next = ST_FIT;
                end
            end
            ST_FIT: begin
                // Step one forms n * mean x, step two the numerator and denominator.
                if (!nd_reg) begin
                    cmd.calc_mx = 1'b1;
                    nd_next     = 1'b1;
                end else begin
                    cmd.calc_nd = 1'b1;
                    state_next  = ST_SLOPE;
                end
            end
            ST_SLOPE: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = ST_SLOPEW;
            end
            ST_SLOPEW: begin
                cmd.div_sel = 1'b1;
                if (sts.div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            nd_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            nd_reg    <= nd_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

FILE: rtl/pressure_trend_kill_trigger.sv
// ----------------------------------------------------------------------------
// pressure_trend_kill_trigger
// Fits a pressure trend over a sliding sample window and raises a kill request.
// ----------------------------------------------------------------------------
// Each event runs a sum pass over the window, the mean divide, the fit and the
// slope divide; a lone sample skips all but the sum pass. A new event is taken
// only once the last one's result is loaded, so the divider, used twice, and
// the sum pass set the event rate.
// Reset: synchronous, active low; it empties the window and restores the
// register reset values. The result register lets the next event start early.
module pressure_trend_kill_trigger #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ptkt_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output ptkt_pkg::out_t m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [19:0]    cfg_data
);
    import ptkt_pkg::*;

    cmd_t cmd;
    sts_t sts;
    cfg_t cfg_reg;

    // Configuration writes are always taken; an unknown index is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.swap_reserve_kb     <= 20'd65536;
            cfg_reg.anon_min_pct        <= 7'd15;
            cfg_reg.clean_min_pct       <= 7'd15;
            cfg_reg.slope_threshold     <= 10'd50;
            cfg_reg.hard_pressure_limit <= 10'd500;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SWAP_RESERVE: cfg_reg.swap_reserve_kb     <= cfg_data;
                REG_ANON_MIN:     cfg_reg.anon_min_pct        <= cfg_data[6:0];
                REG_CLEAN_MIN:    cfg_reg.clean_min_pct       <= cfg_data[6:0];
                REG_SLOPE_THR:    cfg_reg.slope_threshold     <= cfg_data[9:0];
                REG_HARD_LIMIT:   cfg_reg.hard_pressure_limit <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // The controller walks each event through its steps; the datapath holds
    // the window, the sums, the divider and the result register.
    ptkt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ptkt_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .cfg     (cfg_reg),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

FILE: rtl/ptkt_checker.sv
// ----------------------------------------------------------------------------
// ptkt_checker
// Port-level checks of the pressure trend kill trigger.
// ----------------------------------------------------------------------------
module ptkt_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input ptkt_pkg::out_t m_data
);
    import ptkt_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !m_valid || !s_ready)
        else $error("input taken again right after a transaction");

    a_kill_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.kill_request ==
                    (m_data.regression || m_data.swap_short))
        else $error("kill request disagrees with its causes");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind pressure_trend_kill_trigger ptkt_checker u_ptkt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: test/pressure_trend_kill_trigger_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pressure_trend_kill_trigger_test
// Self-checking bench for the pressure trend kill trigger. Directed events
// cover the field extremes, every pressure level and the slope, floor and
// reclaim rules; random events follow under changing idle patterns and a
// long output stall. A scoreboard predicts each result and compares it.
// ----------------------------------------------------------------------------
module pressure_trend_kill_trigger_test;
    import ptkt_pkg::*;

    // Prediction and comparison of kill decisions.
    class kill_scoreboard;
        bit [19:0] swap_reserve = 20'd65536;
        bit [6:0]  anon_pct = 7'd15;
        bit [6:0]  clean_pct = 7'd15;
        bit [9:0]  slope_thr = 10'd50;
        bit [9:0]  hard_lim = 10'd500;
        bit [6:0]  samples[8];
        int        wr_ptr;
        int        fill;
        out_t      pending[$];
        int        errors;
        int        checked;

        function void write_reg(bit [2:0] idx, bit [19:0] val);
            case (idx)
                REG_SWAP_RESERVE: swap_reserve = val;
                REG_ANON_MIN:     anon_pct = val[6:0];
                REG_CLEAN_MIN:    clean_pct = val[6:0];
                REG_SLOPE_THR:    slope_thr = val[9:0];
                REG_HARD_LIMIT:   hard_lim = val[9:0];
                default: ;
            endcase
        endfunction

        // Integer least-squares slope of the window, oldest first.
        function longint window_slope();
            longint sx, sy, sxy, sxx, mx, my, num, den, s, y;
            int first;
            sx = 0; sy = 0; sxy = 0; sxx = 0;
            if (fill < 2) return 0;
            first = (wr_ptr + 8 - fill) % 8;
            for (int i = 0; i < fill; i++) begin
                y = samples[(first + i) % 8];
                sx += i; sy += y; sxy += i * y; sxx += i * i;
            end
            mx = sx / fill;
            my = sy / fill;
            num = sxy - fill * mx * my;
            den = sxx - fill * mx * mx;
            s = (den != 0) ? num / den : 0;
            if (s > 2047) s = 2047;
            if (s < -2048) s = -2048;
            return s;
        endfunction

        function void note_event(in_t ev);
            out_t r;
            bit [39:0] clean;
            bit [47:0] afloor, cfloor;
            longint s;
            bit reg_hit;
            clean = (ev.file_kb > ev.dirty_file_kb) ? ev.file_kb - ev.dirty_file_kb
                                                    : 40'd0;
            afloor = (48'(ev.total_kb) * anon_pct) / 100;
            cfloor = (48'(ev.total_kb) * clean_pct) / 100;
            r.anon_starved = 48'(ev.anon_kb) < afloor;
            r.clean_starved = 48'(clean) < cfloor;
            r.swap_short = ev.swap_avail_kb < 40'(swap_reserve);
            samples[wr_ptr] = ev.pressure;
            wr_ptr = (wr_ptr + 1) % 8;
            if (fill < 8) fill++;
            s = window_slope();
            reg_hit = (ev.pressure >= hard_lim) || (s >= longint'(slope_thr)) ||
                      (ev.alloc_failure_count != 0) || (ev.level >= LEVEL_CRITICAL);
            if (r.clean_starved && ev.swap_refault_count != 0) reg_hit = 1;
            if (ev.reactivation_count > 4 && ev.scanned_pages != 0 &&
                (64'(ev.reclaimed_pages) * 100) / ev.scanned_pages < 10)
                reg_hit = 1;
            r.regression = reg_hit;
            r.kill_request = reg_hit || r.swap_short;
            r.trend_slope = s[11:0];
            pending.push_back(r);
        endfunction

        function void check_result(out_t got);
            out_t exp;
            checked++;
            if (pending.size() == 0) begin
                $error("result with no event outstanding: %p", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.kill_request !== exp.kill_request) begin
                $error("kill_request exp %0d got %0d", exp.kill_request, got.kill_request);
                errors++;
            end
            if (got.regression !== exp.regression) begin
                $error("regression exp %0d got %0d", exp.regression, got.regression);
                errors++;
            end
            if (got.trend_slope !== exp.trend_slope) begin
                $error("trend_slope exp %0d got %0d", exp.trend_slope, got.trend_slope);
                errors++;
            end
            if (got.anon_starved !== exp.anon_starved) begin
                $error("anon_starved exp %0d got %0d", exp.anon_starved,
                       got.anon_starved);
                errors++;
            end
            if (got.clean_starved !== exp.clean_starved) begin
                $error("clean_starved exp %0d got %0d", exp.clean_starved,
                       got.clean_starved);
                errors++;
            end
            if (got.swap_short !== exp.swap_short) begin
                $error("swap_short exp %0d got %0d", exp.swap_short,
                       got.swap_short);
                errors++;
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_t        s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_t       m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [19:0] cfg_data = '0;

    kill_scoreboard sb = new();

    // Idle percentages for each side, and a long output stall request.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_output = 1'b0;
    int sent = 0;

    pressure_trend_kill_trigger DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // The receiver decides m_ready for the next edge, and the scoreboard
    // sees every result transaction that completes at this edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        m_ready <= !hold_output && ($urandom_range(99) >= recv_idle_pct);
    end

    // Writes one register while the block is idle.
    task automatic write_register(input logic [2:0] idx, input logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    // Offers one event, with a random gap first, and holds it until accepted.
    task automatic send_event(input in_t ev);
        while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_valid <= 1'b1;
        s_data <= ev;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        s_valid <= 1'b0;
        sb.note_event(ev);
        sent++;
        @(posedge aclk);
    endtask

    // Lets every outstanding result drain, then some slack for the pipeline.
    task automatic drain_results();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic logic [39:0] rand40();
        return {8'($urandom), 32'($urandom)};
    endfunction

    // Random event. Memory sizes are mostly picked near their floors so that
    // both sides of each comparison show up; some use the full 40-bit range.
    function automatic in_t random_event(int trend);
        in_t ev;
        logic [39:0] tot;
        ev.pressure = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                               : 7'($urandom_range(100));
        ev.level = 2'($urandom_range(3));
        ev.reactivation_count = ($urandom_range(3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(8));
        ev.alloc_failure_count = ($urandom_range(4) == 0) ? 16'($urandom) : 16'd0;
        ev.swap_refault_count = ($urandom_range(1) == 0) ? 16'($urandom) : 16'd0;
        ev.scanned_pages = ($urandom_range(5) == 0) ? 32'd0 : 32'($urandom);
        ev.reclaimed_pages = ($urandom_range(1) == 0) ? 32'($urandom)
                             : 32'(ev.scanned_pages / 32'($urandom_range(5, 30)));
        if ($urandom_range(3) == 0) begin
            tot = rand40();
            ev.anon_kb = rand40();
            ev.file_kb = rand40();
            ev.dirty_file_kb = rand40();
            ev.swap_avail_kb = rand40();
        end else begin
            tot = 40'($urandom_range(1 << 24));
            ev.anon_kb = 40'((64'(tot) * $urandom_range(40)) / 100);
            ev.file_kb = 40'((64'(tot) * $urandom_range(50)) / 100);
            ev.dirty_file_kb = 40'((64'(ev.file_kb) * $urandom_range(100)) / 60);
            ev.swap_avail_kb = 40'($urandom_range(140000));
        end
        ev.total_kb = tot;
        // Climbing runs push the slope over its threshold now and then.
        if (trend != 0) ev.pressure = 7'((sent % 8) * trend);
        ev.pressure = ev.pressure;
        return ev;
    endfunction

    initial begin
        in_t ev;
        logic [19:0] lim;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed events under reset configuration.
        ev = '0;
        ev.total_kb = 40'd1000; ev.anon_kb = 40'd500; ev.file_kb = 40'd500;
        ev.swap_avail_kb = 40'd100000;
        send_event(ev);                              // one sample: zero slope, quiet
        for (int i = 1; i < 8; i++) begin
            ev.pressure = 7'(i * 14);                // steep climb, slope under the threshold
            send_event(ev);
        end
        ev.pressure = 7'd127;                        // pressure above the scale
        ev.level = 2'd3;                             // level code three
        send_event(ev);
        ev.pressure = 7'd0;                          // sharp fall, slope still positive
        ev.level = 2'd1;
        send_event(ev);
        ev.level = 2'd2;
        send_event(ev);
        ev.level = 2'd0;
        ev.alloc_failure_count = 16'hFFFF;
        send_event(ev);
        ev.alloc_failure_count = '0;
        ev.file_kb = 40'd100; ev.dirty_file_kb = 40'd200; // dirty exceeds file
        ev.swap_refault_count = 16'hFFFF;
        send_event(ev);
        ev.swap_refault_count = '0;
        ev.reactivation_count = 16'hFFFF;            // churn with poor reclaim
        ev.scanned_pages = 32'hFFFF_FFFF; ev.reclaimed_pages = 32'd1;
        send_event(ev);
        ev.reclaimed_pages = 32'hFFFF_FFFF;
        send_event(ev);
        ev = '1;                                     // all fields at their tops
        send_event(ev);
        ev = '0;                                     // zero memory, swap breach
        send_event(ev);
        drain_results();

        // Extremes of every register: zero floors and limits, then the tops.
        write_register(REG_SWAP_RESERVE, 20'd0);
        write_register(REG_ANON_MIN, 20'd0);
        write_register(REG_CLEAN_MIN, 20'd0);
        write_register(REG_SLOPE_THR, 20'd0);
        write_register(REG_HARD_LIMIT, 20'd0);
        write_register(3'd7, 20'hFFFFF);             // unmapped index, ignored
        for (int i = 0; i < 4; i++) send_event(random_event(0));
        drain_results();
        write_register(REG_SWAP_RESERVE, 20'hFFFFF);
        write_register(REG_ANON_MIN, 20'd127);
        write_register(REG_CLEAN_MIN, 20'd127);
        write_register(REG_SLOPE_THR, 20'd1023);
        write_register(REG_HARD_LIMIT, 20'd1023);
        for (int i = 0; i < 4; i++) send_event(random_event(0));
        drain_results();

        // Random phases, each with its own register setting and idle pattern.
        for (int ph = 0; ph < 6; ph++) begin
            lim = (ph % 2) ? 20'($urandom_range(60, 110)) : 20'd500;
            write_register(REG_SWAP_RESERVE, 20'($urandom_range(1, 140000)));
            write_register(REG_ANON_MIN, 20'($urandom_range(100)));
            write_register(REG_CLEAN_MIN, 20'($urandom_range(100)));
            write_register(REG_SLOPE_THR, 20'($urandom_range(1, 20)));
            write_register(REG_HARD_LIMIT, lim);
            send_idle_pct = (ph < 2) ? 30 : (ph < 4) ? 87 : 0;
            recv_idle_pct = (ph < 2) ? 87 : (ph < 4) ? 30 : 0;
            for (int i = 0; i < 135; i++)
                send_event(random_event(($urandom_range(4) == 0) ? $urandom_range(1, 14) : 0));
            drain_results();
        end

        $display("Covered %0d events over directed cases, register extremes and",
                 sent);
        $display("six random phases with input and output idling and a long stall.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Long output stall while events keep coming, so the input backs up.
    initial begin
        @(posedge aresetn);
        wait (sent >= 300);
        hold_output = 1'b1;
        repeat (600) @(posedge aclk);
        hold_output = 1'b0;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: files.f
rtl/ptkt_pkg.sv
rtl/ptkt_div.sv
rtl/ptkt_dp.sv
rtl/ptkt_ctrl.sv
rtl/pressure_trend_kill_trigger.sv
rtl/ptkt_checker.sv
test/pressure_trend_kill_trigger_test.sv
